/* src/ppgc_pkg.sv */
// ----------------------------------------------------------------------------
// ppgc_pkg
// shared types, constants and the arctangent table for the pose controller
// ----------------------------------------------------------------------------
`default_nettype none
package ppgc_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = 5;

  // angle constants, Q3.13 and Q16 accumulator
  localparam logic signed [17:0] Pi13 = 18'sd25736;
  localparam logic signed [17:0] HalfPi13 = 18'sd12868;
  localparam logic signed [17:0] TwoPi13 = 18'sd51472;
  localparam logic signed [20:0] Pi16 = 21'sd205887;
  localparam logic signed [20:0] HalfPi16 = 21'sd102944;

  // register indexes
  localparam logic [2:0] RegTargetX = 3'd0;
  localparam logic [2:0] RegTargetY = 3'd1;
  localparam logic [2:0] RegTargetHeading = 3'd2;
  localparam logic [2:0] RegGainRho = 3'd3;
  localparam logic [2:0] RegGainAlpha = 3'd4;
  localparam logic [2:0] RegGainBeta = 3'd5;
  localparam logic [2:0] RegArriveRadius = 3'd6;
  localparam logic [2:0] RegMaxSpeed = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_SQY,
    ST_NEAR,
    ST_SQRT,
    ST_CORDIC,
    ST_ANGLES,
    ST_SPEED,
    ST_MULA,
    ST_MULB,
    ST_DONE
  } state_t;

  // arctangent of 2^-i, 2^16 per radian
  function automatic logic [15:0] atan_q16(input logic [StepW-1:0] i);
    logic [15:0] r;
    begin
      case (i)
        5'd0: r = 16'd51472;
        5'd1: r = 16'd30386;
        5'd2: r = 16'd16055;
        5'd3: r = 16'd8150;
        5'd4: r = 16'd4091;
        5'd5: r = 16'd2047;
        5'd6: r = 16'd1024;
        5'd7: r = 16'd512;
        5'd8: r = 16'd256;
        5'd9: r = 16'd128;
        5'd10: r = 16'd64;
        5'd11: r = 16'd32;
        5'd12: r = 16'd16;
        5'd13: r = 16'd8;
        5'd14: r = 16'd4;
        5'd15: r = 16'd2;
        5'd16: r = 16'd1;
        default: r = 16'd0;
      endcase
      return r;
    end
  endfunction

  // wrap into (-pi, pi] for inputs within (-3pi, 3pi)
  function automatic logic signed [17:0] wrap13(input logic signed [17:0] a);
    logic signed [17:0] m;
    begin
      m = a;
      if (m > Pi13) m = m - TwoPi13;
      else if (m <= -Pi13) m = m + TwoPi13;
      if (m > Pi13) m = m - TwoPi13;
      else if (m <= -Pi13) m = m + TwoPi13;
      return m;
    end
  endfunction

endpackage
`default_nettype wire

/* src/ppgc_isqrt.sv */
// ----------------------------------------------------------------------------
// ppgc_isqrt
// bit-serial integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module ppgc_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [49:0] radicand,
  output logic             busy,
  output logic [24:0]      root
);
  import ppgc_pkg::*;

  logic [49:0] rem;
  logic [49:0] acc;
  logic [49:0] bitv;
  logic [49:0] trial;

  assign trial = acc + bitv;

  // restoring square root walking down two bits per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem <= radicand;
      acc <= '0;
      bitv <= 50'd1 << 48;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        acc <= (acc >> 1) + bitv;
      end else begin
        acc <= acc >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv[0]) busy <= 1'b0;
    end
  end

  assign root = acc[24:0];

  // the search stops exactly when the last bit has been tried
  a_bit_grid: assert property (@(posedge clk) disable iff (rst)
    busy |-> ($onehot(bitv) && ((bitv & 50'h1555555555555) != '0)))
    else $error("root bit weight off its grid");
endmodule
`default_nettype wire

/* src/polar_pose_goto_controller.sv */
// ----------------------------------------------------------------------------
// polar_pose_goto_controller
// polar pose controller: distance, bearing, wrapped angles, speed and rate
// ----------------------------------------------------------------------------
// channel | direction | words
// cfg     | in        | cfg_index, cfg_data
// pose    | in        | pose_x, pose_y, pose_heading
// cmd     | out       | linear_speed, angular_rate, arrived
//
// one pose goes from acceptance to the command word through offsets, squares
// and the radius test, the root, 16 CORDIC steps, then angles, speed, two rate
// multiplies and the output register. a pose inside the radius skips from the
// radius test straight to the output register.
// in_ready and cfg_ready are low from acceptance until the command word is
// taken. an arrival latches goal_reached; poses are then dropped without a
// word until a target register is written. reset is synchronous.
`default_nettype none
module polar_pose_goto_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [23:0] pose_x,
  input  wire logic signed [23:0] pose_y,
  input  wire logic signed [15:0] pose_heading,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] linear_speed,
  output logic signed [15:0] angular_rate,
  output logic             arrived
);
  import ppgc_pkg::*;

  logic signed [23:0] target_x, target_y;
  logic signed [15:0] target_heading, gain_alpha, gain_beta;
  logic [15:0] gain_rho;
  logic [22:0] arrive_radius;
  logic [14:0] max_speed;
  logic goal_reached;

  state_t state, state_next;
  logic signed [23:0] px, py;
  logic signed [15:0] ph;
  logic signed [24:0] dx, dy;
  logic [49:0] d2;
  logic signed [42:0] cx, cy;
  logic signed [20:0] cz;
  logic [StepW-1:0] step;
  logic sq_start, sq_busy;
  logic [24:0] rho;
  logic signed [17:0] alpha, beta;
  logic rev;
  logic signed [16:0] speed;
  logic signed [34:0] wacc;
  logic near;

  assign cfg_ready = (state == ST_IDLE) && !out_valid;
  assign in_ready = (state == ST_IDLE) && !out_valid;

  ppgc_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(d2),
    .busy(sq_busy), .root(rho)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0; target_y <= '0; target_heading <= '0;
      gain_rho <= '0; gain_alpha <= '0; gain_beta <= '0;
      arrive_radius <= 23'd410; max_speed <= 15'd2048;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegTargetX: target_x <= cfg_data;
        RegTargetY: target_y <= cfg_data;
        RegTargetHeading: target_heading <= cfg_data[15:0];
        RegGainRho: gain_rho <= cfg_data[15:0];
        RegGainAlpha: gain_alpha <= cfg_data[15:0];
        RegGainBeta: gain_beta <= cfg_data[15:0];
        RegArriveRadius: arrive_radius <= cfg_data[22:0];
        RegMaxSpeed: max_speed <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // shared datapath values
  logic signed [42:0] xs, ys;
  logic signed [20:0] zc;
  logic signed [17:0] gam;
  logic signed [51:0] prod;
  logic [40:0] vmul;
  logic signed [17:0] a1, b1;
  logic signed [34:0] wsh;

  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign zc = (cz > Pi16) ? Pi16 : ((cz < -Pi16) ? -Pi16 : cz);
  assign gam = 18'((zc + 21'sd4) >>> 3);
  assign vmul = 41'(gain_rho) * 41'(rho);
  assign a1 = wrap13(18'(gam) - 18'(ph));
  assign b1 = wrap13(18'(target_heading) - gam);
  assign wsh = wacc >>> 13;

  // one multiplier shared by the squares and the rate terms
  logic signed [25:0] ma;
  logic signed [25:0] mb;
  always_comb begin
    ma = 26'(dx); mb = 26'(dx);
    case (state)
      ST_SQY: begin ma = 26'(dy); mb = 26'(dy); end
      ST_MULA: begin ma = 26'(gain_alpha); mb = 26'(alpha); end
      ST_MULB: begin ma = 26'(gain_beta); mb = 26'(beta); end
      default: begin ma = 26'(dx); mb = 26'(dx); end
    endcase
  end
  assign prod = 52'(ma) * 52'(mb);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    sq_start = 1'b0;
    unique case (state)
      ST_IDLE: if (in_valid && in_ready && !goal_reached) state_next = ST_DIFF;
      ST_DIFF: state_next = ST_SQ;
      ST_SQ: state_next = ST_SQY;
      ST_SQY: state_next = ST_NEAR;
      ST_NEAR: begin
        if (near) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SQRT;
          sq_start = 1'b1;
        end
      end
      ST_SQRT: if (!sq_busy) state_next = ST_CORDIC;
      ST_CORDIC: if (step == StepW'(CordicSteps - 1)) state_next = ST_ANGLES;
      ST_ANGLES: state_next = ST_SPEED;
      ST_SPEED: state_next = ST_MULA;
      ST_MULA: state_next = ST_MULB;
      ST_MULB: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic [49:0] r2;
  assign r2 = 50'({27'd0, arrive_radius} * {27'd0, arrive_radius});

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      goal_reached <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready && (cfg_index == RegTargetX ||
          cfg_index == RegTargetY || cfg_index == RegTargetHeading))
        goal_reached <= 1'b0;
      if (state == ST_DONE) begin
        out_valid <= 1'b1;
        if (near) begin
          goal_reached <= 1'b1;
          linear_speed <= '0; angular_rate <= '0; arrived <= 1'b1;
        end else begin
          linear_speed <= rev ? 16'(-speed) : 16'(speed);
          angular_rate <= (wsh > 35'sd32767) ? 16'sh7fff :
                          (wsh < -35'sd32768) ? 16'sh8000 : 16'(wsh);
          arrived <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin px <= pose_x; py <= pose_y; ph <= pose_heading; end
      ST_DIFF: begin
        dx <= 25'(target_x) - 25'(px);
        dy <= 25'(target_y) - 25'(py);
      end
      ST_SQ: begin
        d2 <= prod[49:0];
        // pre-rotation into the right half plane
        step <= '0;
        if (dx < 0) begin
          if (dy >= 0) begin
            cx <= 43'(dy) <<< 16; cy <= -(43'(dx) <<< 16); cz <= HalfPi16;
          end else begin
            cx <= -(43'(dy) <<< 16); cy <= 43'(dx) <<< 16; cz <= -HalfPi16;
          end
        end else begin
          cx <= 43'(dx) <<< 16; cy <= 43'(dy) <<< 16; cz <= '0;
        end
      end
      ST_SQY: begin
        near <= (d2 + prod[49:0]) <= r2;
        d2 <= d2 + prod[49:0];
      end
      ST_CORDIC: begin
        if (cy > 0) begin
          cx <= cx + ys; cy <= cy - xs; cz <= cz + 21'(atan_q16(step));
        end else begin
          cx <= cx - ys; cy <= cy + xs; cz <= cz - 21'(atan_q16(step));
        end
        step <= step + 1'b1;
      end
      ST_ANGLES: begin
        rev <= (a1 > HalfPi13) || (a1 < -HalfPi13);
        if ((a1 > HalfPi13) || (a1 < -HalfPi13)) begin
          alpha <= wrap13(a1 + Pi13); beta <= wrap13(b1 + Pi13);
        end else begin
          alpha <= a1; beta <= b1;
        end
      end
      ST_SPEED: speed <= ((vmul >> 12) > 41'(max_speed)) ? 17'(max_speed)
                                                         : 17'(vmul >> 12);
      ST_MULA: wacc <= 35'(prod);
      ST_MULB: wacc <= wacc + 35'(prod);
      default: ;
    endcase
  end

  // checks
  a_idle_with_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_IDLE))
    else $error("command word shown while busy");
  a_arrival_latched: assert property (@(posedge clk) disable iff (rst)
    (out_valid && arrived) |-> goal_reached)
    else $error("arrival word without latch");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CORDIC) |-> (step < StepW'(CordicSteps)))
    else $error("cordic step out of range");
endmodule
`default_nettype wire

/* sim/ppgc_checker.sv */
// ----------------------------------------------------------------------------
// ppgc_checker
// watches the config, pose and command channels, predicts each command word
// from the pose and the register shadow, and compares in order
// ----------------------------------------------------------------------------
`default_nettype none
module ppgc_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic signed [23:0] pose_x,
  input  wire logic signed [23:0] pose_y,
  input  wire logic signed [15:0] pose_heading,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic signed [15:0] linear_speed,
  input  wire logic signed [15:0] angular_rate,
  input  wire logic        arrived,
  output int               fail_count,
  output int               pending,
  output int               cmd_count,
  output int               arrive_count
);
  import ppgc_pkg::*;

  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] rate;
    logic               arr;
  } cmd_t;

  cmd_t cmd_queue[$];

  // register shadow
  logic signed [23:0] tgt_x, tgt_y;
  logic signed [15:0] tgt_h, k_alpha, k_beta;
  logic [15:0] k_rho;
  logic [22:0] radius;
  logic [14:0] speed_cap;
  bit latched;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_root(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic int angle_wrap(int a);
    int m;
    m = a % 51472;
    if (m < 0) m += 51472;
    if (m > 25736) m -= 51472;
    return m;
  endfunction

  // cordic vectoring bearing, rounded to Q3.13
  function automatic int bearing(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HalfPi16;
      end else begin
        t = x; x = -y; y = t; z = -HalfPi16;
      end
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z += longint'(atan_q16(i[4:0]));
      end else begin
        x = x - ys; y = y + xs; z -= longint'(atan_q16(i[4:0]));
      end
    end
    if (z > Pi16) z = Pi16;
    if (z < -Pi16) z = -Pi16;
    return int'(shr_floor(z + 4, 3));
  endfunction

  function automatic bit predict_cmd(longint px, longint py, int ph, output cmd_t c);
    longint dx, dy, d2, rho, v, w;
    int g, al, be;
    c = '0;
    if (latched) return 0;
    dx = longint'(tgt_x) - px;
    dy = longint'(tgt_y) - py;
    d2 = dx * dx + dy * dy;
    if (d2 <= longint'(radius) * longint'(radius)) begin
      latched = 1;
      c.arr = 1'b1;
      return 1;
    end
    rho = int_root(d2);
    g = bearing(dx, dy);
    al = angle_wrap(g - ph);
    be = angle_wrap(int'(tgt_h) - g);
    v = (longint'(k_rho) * rho) >>> 12;
    if (v > longint'(speed_cap)) v = longint'(speed_cap);
    if (al > HalfPi13 || al < -HalfPi13) begin
      v = -v;
      al = angle_wrap(al + 25736);
      be = angle_wrap(be + 25736);
    end
    w = longint'(k_alpha) * al + longint'(k_beta) * be;
    w = w >>> 13;
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    c.speed = v[15:0];
    c.rate = w[15:0];
    return 1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // register writes, pose predictions and command compares
  always @(posedge clk) begin
    cmd_t c, exp_c;
    if (rst) begin
      tgt_x <= '0; tgt_y <= '0; tgt_h <= '0;
      k_rho <= '0; k_alpha <= '0; k_beta <= '0;
      radius <= 23'd410; speed_cap <= 15'd2048;
      latched = 0;
      cmd_queue.delete();
      pending <= 0;
      fail_count = 0;
      cmd_count <= 0; arrive_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegTargetX: begin tgt_x <= cfg_data; latched = 0; end
          RegTargetY: begin tgt_y <= cfg_data; latched = 0; end
          RegTargetHeading: begin tgt_h <= cfg_data[15:0]; latched = 0; end
          RegGainRho: k_rho <= cfg_data[15:0];
          RegGainAlpha: k_alpha <= cfg_data[15:0];
          RegGainBeta: k_beta <= cfg_data[15:0];
          RegArriveRadius: radius <= cfg_data[22:0];
          RegMaxSpeed: speed_cap <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (predict_cmd(pose_x, pose_y, pose_heading, c)) cmd_queue.push_back(c);
      end
      if (out_valid && out_ready) begin
        cmd_count <= cmd_count + 1;
        if (arrived) arrive_count <= arrive_count + 1;
        if (cmd_queue.size() == 0) begin
          report_mismatch("unexpected command word", 0, 0);
        end else begin
          exp_c = cmd_queue.pop_front();
          if (linear_speed !== exp_c.speed) report_mismatch("linear_speed", linear_speed, exp_c.speed);
          if (angular_rate !== exp_c.rate) report_mismatch("angular_rate", angular_rate, exp_c.rate);
          if (arrived !== exp_c.arr) report_mismatch("arrived", arrived, exp_c.arr);
        end
      end
      pending <= cmd_queue.size();
    end
  end
endmodule
`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives register settings and poses into the pose controller with random
// gaps and back-pressure; the checker predicts and compares command words
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import ppgc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] pose_x = '0, pose_y = '0;
  logic signed [15:0] pose_heading = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] linear_speed, angular_rate;
  logic arrived;
  int fail_count, pending, cmd_count, arrive_count;

  int send_idle = 0, recv_idle = 0;
  int stall_cycles = 0;
  int pose_count = 0;
  logic signed [23:0] goal_x = '0, goal_y = '0;

  always #5 clk = ~clk;

  polar_pose_goto_controller u_dut (.*);

  ppgc_checker u_chk (.*);

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on accepted words of any channel
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("watchdog expired");
      $display("Verification failed");
      $finish;
    end
  end

  // valid stays high after acceptance until the next task drops or reloads it
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    in_valid <= 1'b0;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == RegTargetX) goal_x <= val;
    if (idx == RegTargetY) goal_y <= val;
  endtask

  // let the block drain, including a pose that produces no word
  task automatic settle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_pose(logic signed [23:0] x, logic signed [23:0] y, logic signed [15:0] h);
    cfg_valid <= 1'b0;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    pose_x <= x;
    pose_y <= y;
    pose_heading <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pose_count++;
  endtask

  function automatic logic [23:0] rand_bits(int w);
    return 24'($urandom) & ((24'd1 << w) - 1);
  endfunction

  // a pose near the goal, at a random scale, sometimes inside the radius; one in ten is anywhere
  task automatic random_pose();
    int sc;
    logic signed [23:0] ox, oy;
    sc = $urandom_range(23);
    ox = $signed(rand_bits(24)) >>> sc;
    oy = $signed(rand_bits(24)) >>> sc;
    if ($urandom_range(9) == 0)
      send_pose(rand_bits(24), rand_bits(24), 16'(rand_bits(16)));
    else send_pose(goal_x - ox, goal_y - oy, 16'(rand_bits(16)));
  endtask

  task automatic random_setting(int mode);
    write_reg(RegTargetX, mode == 1 ? 24'h7fffff : mode == 2 ? 24'h800000 : rand_bits(24) >>> 2);
    write_reg(RegTargetY, mode == 1 ? 24'h800000 : mode == 2 ? 24'h7fffff : rand_bits(24) >>> 2);
    write_reg(RegTargetHeading, mode == 1 ? 24'h7fff : mode == 2 ? 24'h8000 : rand_bits(16));
    write_reg(RegGainRho, mode == 1 ? 24'hffff : mode == 2 ? 24'h0 : rand_bits(16));
    write_reg(RegGainAlpha, mode == 1 ? 24'h7fff : mode == 2 ? 24'h8000 : rand_bits(16));
    write_reg(RegGainBeta, mode == 1 ? 24'h8000 : mode == 2 ? 24'h7fff : rand_bits(16));
    write_reg(RegArriveRadius, mode == 1 ? 24'h7fffff : mode == 2 ? 24'h0 :
              rand_bits($urandom_range(2, 16)));
    write_reg(RegMaxSpeed, mode == 1 ? 24'h7fff : mode == 2 ? 24'h0 : rand_bits(15));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, axis bearings, far corners, arrival latch
    write_reg(RegGainRho, 24'h1000);
    write_reg(RegGainAlpha, 24'h2000);
    write_reg(RegGainBeta, 24'hf000);
    send_pose(24'sd40960, '0, '0);
    send_pose(-24'sd40960, '0, 16'sd25736);
    send_pose('0, 24'sd40960, -16'sd12868);
    send_pose('0, -24'sd40960, 16'sd12869);
    send_pose(24'sd40960, 24'sd40960, 16'sh7fff);
    send_pose(-24'sd40960, -24'sd40960, 16'sh8000);
    send_pose(24'sh7fffff, 24'sh7fffff, '0);
    send_pose(24'sh800000, 24'sh800000, '0);
    send_pose(24'sh800000, 24'sh7fffff, 16'sd100);
    send_pose(24'sd410, '0, '0);
    send_pose(24'sd4096, '0, '0);
    settle();
    write_reg(RegGainRho, 24'h1);
    write_reg(RegMaxSpeed, 24'h0);
    send_pose(24'sd4096, '0, '0);
    settle();
    write_reg(RegTargetHeading, 24'h0100);
    send_pose(24'sd100000, 24'sd5, '0);
    send_pose('0, '0, '0);
    send_pose('0, '0, '0);
    settle();
    random_setting(1);
    send_pose(24'sh800000, 24'sh800000, 16'sh8000);
    send_pose(24'sh7fffff, 24'sh7fffff, 16'sh7fff);
    settle();
    random_setting(2);
    send_pose(24'sh7fffff, 24'sh800000, 16'sh7fff);
    send_pose(24'sh7fffff, 24'sh7fffff, 16'sh7fff);
    settle();

    // random phases with three idling patterns
    for (int ph = 0; ph < 60; ph++) begin
      send_idle = ph < 20 ? 23 : ph < 40 ? 84 : 0;
      recv_idle = ph < 20 ? 84 : ph < 40 ? 23 : 0;
      random_setting(0);
      repeat (29) random_pose();
      settle();
    end

    settle();
    $display("poses sent %0d, command words %0d, arrivals %0d", pose_count, cmd_count,
             arrive_count);
    $display("directed axis, corner and latch cases, then 60 random register settings");
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
src/ppgc_pkg.sv
src/ppgc_isqrt.sv
src/polar_pose_goto_controller.sv
sim/ppgc_checker.sv
sim/tb_top.sv
